// ----- hdl/ppt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the pointer position tracker
// Event modes, key codes, register indexes, reset values and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int MAX_SCREEN_DEF = 4096;

	localparam int SCR_W      = 13;  // screen size register width
	localparam int CODE_W     = 10;
	localparam int VAL_W      = 32;
	localparam int OUT_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [SCR_W-1:0] DEF_WIDTH  = 13'd480;
	localparam logic [SCR_W-1:0] DEF_HEIGHT = 13'd320;

	localparam logic signed [VAL_W-1:0] CURSOR_X_RST = 32'sd240;
	localparam logic signed [VAL_W-1:0] CURSOR_Y_RST = 32'sd160;
	localparam logic signed [VAL_W-1:0] ABS_MIN_RST  = 32'sd0;
	localparam logic signed [VAL_W-1:0] ABS_MAX_RST  = 32'sd4095;

	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

	localparam logic [CODE_W-1:0] CODE_AXIS_X    = 10'd0;
	localparam logic [CODE_W-1:0] CODE_AXIS_Y    = 10'd1;
	localparam logic [CODE_W-1:0] CODE_BTN_LEFT  = 10'd272;
	localparam logic [CODE_W-1:0] CODE_BTN_TOUCH = 10'd330;

	typedef enum logic [1:0] {
		MODE_REL  = 2'd0,
		MODE_ABS  = 2'd1,
		MODE_KEY  = 2'd2,
		MODE_POLL = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH  = 3'd0,
		CFG_SCREEN_HEIGHT = 3'd1,
		CFG_ABS_X_MIN     = 3'd2,
		CFG_ABS_X_MAX     = 3'd3,
		CFG_ABS_Y_MIN     = 3'd4,
		CFG_ABS_Y_MAX     = 3'd5
	} cfg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the accepted request
		logic mark_evt;   // set activity flag
		logic rel_upd;    // relative delta add
		logic key_upd;    // button press check
		logic abs_prep;   // offset, span and size-1 of an absolute request
		logic abs_mul;    // offset magnitude times size-1
		logic div_start;  // launch divider
		logic abs_wr;     // saturate quotient into cursor
		logic poll;       // clamp, emit result, clear flags
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  axis_ok;
		logic  out_free;
		logic  div_busy;
		logic  div_done;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- hdl/ppt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_in_if / ppt_out_if: valid/ready channels of the tracker
// Event requests in, poll results out.
// ----------------------------------------------------------------------------
interface ppt_in_if;
	import ppt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic [CODE_W-1:0]        code;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, mode, code, value, input ready);
	modport sink   (input valid, mode, code, value, output ready);
endinterface

interface ppt_out_if;
	import ppt_pkg::*;

	logic              valid;
	logic              ready;
	logic [OUT_W-1:0]  pos_x_out;
	logic [OUT_W-1:0]  pos_y_out;
	logic              clicked;
	logic              activity;

	modport source (output valid, pos_x_out, pos_y_out, clicked, activity, input ready);
	modport sink   (input valid, pos_x_out, pos_y_out, clicked, activity, output ready);
endinterface
`default_nettype wire

// ----- hdl/ppt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_div: restoring unsigned divider
// One quotient bit per cycle; done pulses once per division.
// ----------------------------------------------------------------------------
module ppt_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] acc_q;  // numerator shifts out, quotient shifts in
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             fit;
	logic [DEN_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, acc_q[NUM_W-1]};
		fit     = (trial >= {1'b0, den_q});
		rem_nxt = fit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], fit};
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = acc_q;
endmodule
`default_nettype wire

// ----- hdl/ppt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_ctrl: request sequencer
// Takes one request at a time, decodes it and steps the datapath through
// the update, the scaling multiply/divide or the poll.
// ----------------------------------------------------------------------------
module ppt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ppt_pkg::dp_sts_t sts,
	output ppt_pkg::dp_cmd_t      cmd
);
	import ppt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					case (sts.mode)
						MODE_ABS:  state_q <= sts.axis_ok ? ST_MUL : ST_IDLE;
						MODE_POLL: state_q <= sts.out_free ? ST_IDLE : ST_DECODE;
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_MUL:       state_q <= ST_DIV_START;
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (sts.div_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.capture = in_valid;
			ST_DECODE: begin
				cmd.mark_evt = (sts.mode != MODE_POLL);
				case (sts.mode)
					MODE_REL:  cmd.rel_upd  = 1'b1;
					MODE_ABS:  cmd.abs_prep = sts.axis_ok;
					MODE_KEY:  cmd.key_upd  = 1'b1;
					MODE_POLL: cmd.poll     = sts.out_free;
					default:   cmd.rel_upd  = 1'b0;
				endcase
			end
			ST_MUL:       cmd.abs_mul   = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV_WAIT:  cmd.abs_wr    = sts.div_done;
			default:      cmd           = '0;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/ppt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_dp: tracker datapath
// Config registers, latched request, cursor and flags, the absolute
// scaling multiply and divider, and the result register.
// ----------------------------------------------------------------------------
module ppt_dp #(
	parameter int MAX_SCREEN = ppt_pkg::MAX_SCREEN_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ppt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [1:0]                         in_mode,
	input  wire logic [ppt_pkg::CODE_W-1:0]         in_code,
	input  wire logic signed [ppt_pkg::VAL_W-1:0]   in_value,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output logic [ppt_pkg::OUT_W-1:0]               pos_x_out,
	output logic [ppt_pkg::OUT_W-1:0]               pos_y_out,
	output logic                                    clicked,
	output logic                                    activity,
	input  wire ppt_pkg::dp_cmd_t                   cmd,
	output ppt_pkg::dp_sts_t                        sts
);
	import ppt_pkg::*;

	localparam int SZ_W  = ($clog2(MAX_SCREEN + 1) > SCR_W) ? $clog2(MAX_SCREEN + 1) : SCR_W;
	localparam int MAG_W = VAL_W + 1;
	localparam int NUM_W = MAG_W + SZ_W;

	function automatic logic [SZ_W-1:0] eff_size(input logic [SCR_W-1:0] r,
	                                             input logic [SCR_W-1:0] dflt);
		if (r < SCR_W'(2)) return SZ_W'(dflt);
		if (SZ_W'(r) > SZ_W'(MAX_SCREEN)) return SZ_W'(MAX_SCREEN);
		return SZ_W'(r);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
	                                                    input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? INT_MIN : INT_MAX;
		return s[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp_pos(input logic signed [VAL_W-1:0] p,
	                                                      input logic [SZ_W-1:0] size);
		if (p[VAL_W-1]) return '0;
		if ($unsigned(p) >= VAL_W'(size)) return $signed(VAL_W'(size - SZ_W'(1)));
		return p;
	endfunction

	// config
	logic [SCR_W-1:0]        scr_w_q, scr_h_q;
	logic signed [VAL_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

	// request and state
	logic [1:0]              mode_q;
	logic [CODE_W-1:0]       code_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] cursor_x_q, cursor_y_q;
	logic                    click_q, event_q;

	// scaling
	logic                    axis_q;   // 0 X, 1 Y
	logic                    neg_q;
	logic [MAG_W-1:0]        mag_q;
	logic [VAL_W-1:0]        span_q;
	logic [SZ_W-1:0]         sm1_q;
	logic [NUM_W-1:0]        prod_q;

	// result
	logic                    out_valid_q;
	logic [OUT_W-1:0]        pos_x_q, pos_y_q;
	logic                    clicked_q, activity_q;

	logic [SZ_W-1:0]         w_eff, h_eff, size_sel;
	logic signed [VAL_W-1:0] lo_sel, hi_sel;
	logic signed [MAG_W-1:0] diff;
	logic                    axis_sel;
	logic signed [VAL_W-1:0] clamp_x, clamp_y, abs_res;
	logic                    div_busy, div_done;
	logic [NUM_W-1:0]        quo;
	logic                    pos_ovf, neg_ovf;

	always_comb begin
		w_eff    = eff_size(scr_w_q, DEF_WIDTH);
		h_eff    = eff_size(scr_h_q, DEF_HEIGHT);
		axis_sel = (code_q == CODE_AXIS_Y);
		lo_sel   = axis_sel ? y_min_q : x_min_q;
		hi_sel   = axis_sel ? y_max_q : x_max_q;
		size_sel = axis_sel ? h_eff : w_eff;
		diff     = {value_q[VAL_W-1], value_q} - {lo_sel[VAL_W-1], lo_sel};
		clamp_x  = clamp_pos(cursor_x_q, w_eff);
		clamp_y  = clamp_pos(cursor_y_q, h_eff);
		pos_ovf  = |quo[NUM_W-1:VAL_W-1];
		neg_ovf  = (|quo[NUM_W-1:VAL_W]) || (quo[VAL_W-1] && |quo[VAL_W-2:0]);
		if (neg_q) abs_res = neg_ovf ? INT_MIN : -$signed(quo[VAL_W-1:0]);
		else       abs_res = pos_ovf ? INT_MAX : $signed(quo[VAL_W-1:0]);
	end

	ppt_div #(
		.NUM_W (NUM_W),
		.DEN_W (VAL_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (span_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q     <= DEF_WIDTH;
			scr_h_q     <= DEF_HEIGHT;
			x_min_q     <= ABS_MIN_RST;
			x_max_q     <= ABS_MAX_RST;
			y_min_q     <= ABS_MIN_RST;
			y_max_q     <= ABS_MAX_RST;
			cursor_x_q  <= CURSOR_X_RST;
			cursor_y_q  <= CURSOR_Y_RST;
			click_q     <= 1'b0;
			event_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data[SCR_W-1:0];
					CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data[SCR_W-1:0];
					CFG_ABS_X_MIN:     x_min_q <= $signed(cfg_data[VAL_W-1:0]);
					CFG_ABS_X_MAX:     x_max_q <= $signed(cfg_data[VAL_W-1:0]);
					CFG_ABS_Y_MIN:     y_min_q <= $signed(cfg_data[VAL_W-1:0]);
					CFG_ABS_Y_MAX:     y_max_q <= $signed(cfg_data[VAL_W-1:0]);
					default:           scr_w_q <= scr_w_q;
				endcase
			end

			if (cmd.mark_evt) event_q <= 1'b1;

			if (cmd.rel_upd) begin
				if (code_q == CODE_AXIS_X) cursor_x_q <= sat_add(cursor_x_q, value_q);
				else if (code_q == CODE_AXIS_Y) cursor_y_q <= sat_add(cursor_y_q, value_q);
			end

			if (cmd.key_upd && (code_q == CODE_BTN_LEFT || code_q == CODE_BTN_TOUCH)
			    && value_q == 32'sd1)
				click_q <= 1'b1;

			if (cmd.abs_wr) begin
				if (axis_q) cursor_y_q <= abs_res;
				else        cursor_x_q <= abs_res;
			end

			// a new result replaces one taken in the same cycle
			if (cmd.poll) begin
				cursor_x_q  <= clamp_x;
				cursor_y_q  <= clamp_y;
				click_q     <= 1'b0;
				event_q     <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= in_mode;
			code_q  <= in_code;
			value_q <= in_value;
		end
		if (cmd.abs_prep) begin
			axis_q <= axis_sel;
			neg_q  <= diff[MAG_W-1];
			mag_q  <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
			span_q <= (hi_sel > lo_sel) ? VAL_W'(hi_sel - lo_sel) : VAL_W'(1);
			sm1_q  <= size_sel - SZ_W'(1);
		end
		if (cmd.abs_mul)
			prod_q <= {{SZ_W{1'b0}}, mag_q} * {{MAG_W{1'b0}}, sm1_q};
		if (cmd.poll) begin
			pos_x_q    <= clamp_x[OUT_W-1:0];
			pos_y_q    <= clamp_y[OUT_W-1:0];
			clicked_q  <= click_q;
			activity_q <= event_q || click_q;
		end
	end

	always_comb begin
		sts.mode     = mode_t'(mode_q);
		sts.axis_ok  = (code_q == CODE_AXIS_X) || (code_q == CODE_AXIS_Y);
		sts.out_free = !out_valid_q || out_ready;
		sts.div_busy = div_busy;
		sts.div_done = div_done;
	end

	assign out_valid = out_valid_q;
	assign pos_x_out = pos_x_q;
	assign pos_y_out = pos_y_q;
	assign clicked   = clicked_q;
	assign activity  = activity_q;
endmodule
`default_nettype wire

// ----- hdl/pointer_position_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pointer_position_tracker: pointer position from a merged input event stream
// Relative, absolute and key events move the cursor and set flags; an
// end-of-poll request clamps the cursor to the screen and returns one result.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A relative, key or unknown event is
// accepted and then decoded. An absolute X/Y event is scaled as
// (value-min)*(size-1)/(max-min) with truncation toward zero and 32-bit
// saturation; after decode it goes through a single registered 33 x SZ_W
// multiply and the restoring divider, which produces one quotient bit per
// cycle, and the saturated quotient is then written to the cursor. A poll
// is accepted and decoded, and emits its result from decode when the result
// register is free; if an earlier result is still held, the poll waits in
// decode until it is taken. Non-poll events are still accepted while a
// result waits. Config writes take effect at once and should be issued only
// with no request in flight. Screen sizes below 2 fall back to 480 x 320, and
// sizes above MAX_SCREEN are limited to it; the reported coordinates are the
// low 12 bits of the clamped position.
// ----------------------------------------------------------------------------
module pointer_position_tracker #(
	parameter int MAX_SCREEN = ppt_pkg::MAX_SCREEN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data,
	ppt_in_if.sink                              in_ch,
	ppt_out_if.source                           out_ch
);
	import ppt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_ready;

	// sequencer: owns the input handshake
	ppt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign in_ch.ready = in_ready;

	// datapath: config, cursor, scaling arithmetic, result register
	ppt_dp #(
		.MAX_SCREEN (MAX_SCREEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_mode   (in_ch.mode),
		.in_code   (in_ch.code),
		.in_value  (in_ch.value),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.pos_x_out (out_ch.pos_x_out),
		.pos_y_out (out_ch.pos_y_out),
		.clicked   (out_ch.clicked),
		.activity  (out_ch.activity),
		.cmd       (cmd),
		.sts       (sts)
	);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------

	// at most one datapath action per cycle, apart from the mark_evt flag
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.rel_upd, cmd.key_upd, cmd.abs_prep,
		          cmd.abs_mul, cmd.div_start, cmd.abs_wr, cmd.poll}))
		else $error("more than one datapath command in a cycle");

	// a new request is never taken while the divider is working
	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.div_busy)
		else $error("request accepted during a division");

	// a poll always leaves a result in the output register
	a_poll_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.poll |=> out_ch.valid)
		else $error("poll issued but no result presented");

	// a click always counts as activity
	a_click_activity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.clicked) |-> out_ch.activity)
		else $error("clicked result without activity");

endmodule
`default_nettype wire
